[hw/rtl/lpa_pkg.sv]
// Shared types and constants for the light pen position averager.
`default_nettype none

package lpa_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_SAMPLE_COUNT  = 2'd0;
    localparam logic [1:0] CFG_RIGHT_MASK    = 2'd1;
    localparam logic [1:0] CFG_MIDDLE_MASK   = 2'd2;

    localparam logic [6:0]  SAMPLE_COUNT_RST = 7'd4;
    localparam logic [15:0] RIGHT_MASK_RST   = 16'h0400;
    localparam logic [15:0] MIDDLE_MASK_RST  = 16'h0100;

    localparam int unsigned AVG_SHIFT = 8;

    typedef struct packed {
        logic               pen_hit;
        logic signed [15:0] pen_x;
        logic signed [15:0] pen_y;
        logic        [15:0] pot_word;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] abs_x;
        logic signed [15:0] abs_y;
        logic               position_valid;
        logic        [2:0]  buttons;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_sel_y;
        logic store_x;
        logic store_y;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic forming;
        logic out_full;
    } t_dp_sts;

endpackage

`default_nettype wire

[hw/rtl/lpa_div.sv]
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module lpa_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [15:0] i_dividend,
    input  wire logic        [6:0]  i_divisor,
    output logic                    o_done,
    output logic             [15:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [15:0] r_mag;
    logic [6:0]  r_rem;
    logic        r_neg;
    logic [6:0]  r_div;

    logic [15:0] dividend_mag;
    logic [7:0]  rem_shift;
    logic        rem_ge;
    logic [7:0]  rem_sub;

    assign dividend_mag = i_dividend[15] ? (~i_dividend + 16'd1) : i_dividend;
    assign rem_shift    = {r_rem, r_mag[15]};
    assign rem_ge       = rem_shift >= {1'b0, r_div};
    assign rem_sub      = rem_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 4'd15;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 4'd1;
            if (r_cnt == 4'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= dividend_mag;
            r_rem <= '0;
            r_neg <= i_dividend[15];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_mag <= {r_mag[14:0], rem_ge};
            r_rem <= rem_ge ? rem_sub[6:0] : rem_shift[6:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_mag + 16'd1) : r_mag;

endmodule

`default_nettype wire

[hw/rtl/lpa_dp.sv]
// Datapath: config registers, accumulators, smoothed position and output register.
`default_nettype none

module lpa_dp (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [1:0]              i_cfg_idx,
    input  wire logic [15:0]             i_cfg_wdata,
    input  wire lpa_pkg::t_in_item       i_in_item,
    input  wire logic                    i_out_stall,
    input  wire lpa_pkg::t_dp_cmd        i_cmd,
    input  wire logic [15:0]             i_quotient,
    output lpa_pkg::t_dp_sts             o_sts,
    output logic signed [15:0]           o_dividend,
    output logic [6:0]                   o_divisor,
    output logic                         o_out_valid,
    output lpa_pkg::t_out_item           o_out_item
);

    logic [6:0]  r_sample_count;
    logic [15:0] r_right_mask;
    logic [15:0] r_middle_mask;

    logic [15:0] r_smooth_x;
    logic [15:0] r_smooth_y;
    logic        r_valid_flag;
    logic [15:0] r_sum_x;
    logic [15:0] r_sum_y;
    logic [6:0]  r_tick_index;
    logic [6:0]  r_hit_count;

    // Operands held for the divider across a forming request
    logic [15:0] r_hold_x;
    logic [15:0] r_hold_y;
    logic [6:0]  r_hold_cnt;

    logic                r_out_valid;
    lpa_pkg::t_out_item  r_out_item;

    logic        forming;
    logic [2:0]  buttons;
    logic [15:0] avg_shifted;

    assign forming = r_tick_index == r_sample_count;
    assign buttons = {((i_in_item.pot_word & r_middle_mask) == 16'd0),
                      ((i_in_item.pot_word & r_right_mask) == 16'd0),
                      1'b0};
    // Only the low byte of the quotient survives the shift
    assign avg_shifted = (r_hold_cnt == 7'd0) ? 16'd0
                       : {i_quotient[15-lpa_pkg::AVG_SHIFT:0], {lpa_pkg::AVG_SHIFT{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= lpa_pkg::SAMPLE_COUNT_RST;
            r_right_mask   <= lpa_pkg::RIGHT_MASK_RST;
            r_middle_mask  <= lpa_pkg::MIDDLE_MASK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lpa_pkg::CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_wdata[6:0];
                lpa_pkg::CFG_RIGHT_MASK:   r_right_mask   <= i_cfg_wdata;
                lpa_pkg::CFG_MIDDLE_MASK:  r_middle_mask  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth_x   <= '0;
            r_smooth_y   <= '0;
            r_valid_flag <= 1'b0;
            r_sum_x      <= '0;
            r_sum_y      <= '0;
            r_tick_index <= '0;
            r_hit_count  <= '0;
        end else begin
            if (i_cmd.accept) begin
                if (forming) begin
                    r_valid_flag <= r_hit_count >= {1'b0, r_sample_count[6:1]};
                    r_sum_x      <= '0;
                    r_sum_y      <= '0;
                    r_tick_index <= '0;
                    r_hit_count  <= '0;
                end else begin
                    r_tick_index <= r_tick_index + 7'd1;
                    if (i_in_item.pen_hit) begin
                        r_hit_count <= r_hit_count + 7'd1;
                        r_sum_x     <= r_sum_x + i_in_item.pen_x;
                        r_sum_y     <= r_sum_y + i_in_item.pen_y;
                    end
                end
            end
            if (i_cmd.store_x) begin
                r_smooth_x <= avg_shifted;
            end
            if (i_cmd.store_y) begin
                r_smooth_y <= avg_shifted;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && forming) begin
            r_hold_x   <= r_sum_x;
            r_hold_y   <= r_sum_y;
            r_hold_cnt <= r_hit_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_out_item.abs_x          <= r_smooth_x;
            r_out_item.abs_y          <= r_smooth_y;
            r_out_item.position_valid <= r_valid_flag;
            r_out_item.buttons        <= buttons;
        end
    end

    assign o_sts.forming  = forming;
    assign o_sts.out_full = r_out_valid;
    assign o_dividend     = i_cmd.div_sel_y ? r_hold_y : r_hold_x;
    assign o_divisor      = r_hold_cnt;
    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out_item;

endmodule

`default_nettype wire

[hw/rtl/lpa_ctrl.sv]
// Controller: request acceptance and sequencing of the two divisions on a forming tick.
`default_nettype none

module lpa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_out_stall,
    input  wire lpa_pkg::t_dp_sts  i_sts,
    input  wire logic              i_div_done,
    output logic                   o_in_stall,
    output lpa_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y
    } t_state;

    t_state r_state;
    logic   r_div_start;
    logic   r_sel_y;
    logic   accept;

    // Output register frees up when it is taken this cycle
    assign o_in_stall = (r_state != ST_IDLE) || (i_sts.out_full && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_start <= 1'b0;
            r_sel_y     <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept && i_sts.forming) begin
                        r_state     <= ST_DIV_X;
                        r_div_start <= 1'b1;
                        r_sel_y     <= 1'b0;
                    end
                end
                ST_DIV_X: begin
                    if (i_div_done) begin
                        r_state     <= ST_DIV_Y;
                        r_div_start <= 1'b1;
                        r_sel_y     <= 1'b1;
                    end
                end
                ST_DIV_Y: begin
                    if (i_div_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_cmd.accept    = accept;
    assign o_cmd.div_start = r_div_start;
    assign o_cmd.div_sel_y = r_sel_y;
    assign o_cmd.store_x   = (r_state == ST_DIV_X) && i_div_done;
    assign o_cmd.store_y   = (r_state == ST_DIV_Y) && i_div_done;

endmodule

`default_nettype wire

[hw/rtl/light_pen_position_averager_core.sv]
// Top level of the light pen position averager.
//
//  channel   direction  handshake                   payload
//  in        input      i_in_valid / o_in_stall     i_in_item  (lpa_pkg::t_in_item)
//  out       output     o_out_valid / i_out_stall   o_out_item (lpa_pkg::t_out_item)
//  cfg       input      i_cfg_we                    i_cfg_idx, i_cfg_wdata
//
// An ordinary tick's result is registered and offered on the output the next cycle.
// A forming tick (tick count reached sample_count) then runs two 16-step serial
// divisions on one shared divider, during which input is stalled.
// Input is also stalled while the output register holds an untaken result.
// Reset is synchronous, active low, and restores the register defaults.
`default_nettype none

module light_pen_position_averager_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [15:0]         i_cfg_wdata,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire lpa_pkg::t_in_item   i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output lpa_pkg::t_out_item       o_out_item
);

    lpa_pkg::t_dp_cmd   cmd;
    lpa_pkg::t_dp_sts   sts;
    logic               div_done;
    logic [15:0]        quotient;
    logic signed [15:0] dividend;
    logic [6:0]         divisor;

    lpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .i_div_done  (div_done),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    lpa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .i_quotient  (quotient),
        .o_sts       (sts),
        .o_dividend  (dividend),
        .o_divisor   (divisor),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    lpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

`ifndef SYNTH
    a_accept_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> o_out_valid)
        else $error("accepted request did not produce a result");

    a_forming_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.accept && sts.forming) |=> o_in_stall)
        else $error("forming request did not stall input");

    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (o_in_stall && !cmd.accept))
        else $error("divider finished outside a forming sequence");
`endif

endmodule

`default_nettype wire

[tb/tb_light_pen_position_averager_core.sv]
// Self-checking testbench for the light pen position averager core.
`default_nettype none

module tb_light_pen_position_averager_core;

    localparam int RIGHT_BIT  = 1;
    localparam int MIDDLE_BIT = 2;
    localparam int SETTLE_CYCLES = 60;

    class pen_average_scoreboard;
        logic [6:0]  frame_len;
        logic [15:0] rmask;
        logic [15:0] mmask;
        logic [15:0] avg_x;
        logic [15:0] avg_y;
        logic        pos_ok;
        logic [15:0] acc_x;
        logic [15:0] acc_y;
        logic [6:0]  tick_cnt;
        logic [6:0]  hits;
        lpa_pkg::t_out_item expected_reports[$];
        int unsigned errors;

        function new();
            frame_len = lpa_pkg::SAMPLE_COUNT_RST;
            rmask     = lpa_pkg::RIGHT_MASK_RST;
            mmask     = lpa_pkg::MIDDLE_MASK_RST;
            avg_x     = '0;
            avg_y     = '0;
            pos_ok    = 1'b0;
            acc_x     = '0;
            acc_y     = '0;
            tick_cnt  = '0;
            hits      = '0;
            errors    = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [15:0] data);
            case (idx)
                lpa_pkg::CFG_SAMPLE_COUNT: frame_len = data[6:0];
                lpa_pkg::CFG_RIGHT_MASK:   rmask = data;
                lpa_pkg::CFG_MIDDLE_MASK:  mmask = data;
                default: ;
            endcase
        endfunction

        // signed mean truncated toward zero, then scaled and cut to 16 bits
        function logic [15:0] mean_shifted(logic [15:0] acc, logic [6:0] cnt);
            int q;
            int scaled;
            if (cnt == 7'd0)
                return 16'h0000;
            q = int'($signed(acc)) / int'(cnt);
            scaled = q << lpa_pkg::AVG_SHIFT;
            return scaled[15:0];
        endfunction

        function void note_tick(lpa_pkg::t_in_item req);
            lpa_pkg::t_out_item e;
            e.abs_x          = avg_x;
            e.abs_y          = avg_y;
            e.position_valid = pos_ok;
            e.buttons        = 3'b000;
            if ((req.pot_word & rmask) == 16'h0000)
                e.buttons[RIGHT_BIT] = 1'b1;
            if ((req.pot_word & mmask) == 16'h0000)
                e.buttons[MIDDLE_BIT] = 1'b1;
            if (tick_cnt == frame_len) begin
                avg_x    = mean_shifted(acc_x, hits);
                avg_y    = mean_shifted(acc_y, hits);
                pos_ok   = (hits >= (frame_len >> 1));
                tick_cnt = '0;
                hits     = '0;
                acc_x    = '0;
                acc_y    = '0;
            end else begin
                tick_cnt = tick_cnt + 7'd1;
                if (req.pen_hit) begin
                    hits  = hits + 7'd1;
                    acc_x = acc_x + req.pen_x;
                    acc_y = acc_y + req.pen_y;
                end
            end
            expected_reports.push_back(e);
        endfunction

        task report_mismatch(string what);
            if (errors < 30)
                $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_report(lpa_pkg::t_out_item got);
            lpa_pkg::t_out_item e;
            if (expected_reports.size() == 0) begin
                report_mismatch("result with no request pending");
                return;
            end
            e = expected_reports.pop_front();
            if (got.abs_x !== e.abs_x)
                report_mismatch($sformatf("abs_x %h, want %h", got.abs_x, e.abs_x));
            if (got.abs_y !== e.abs_y)
                report_mismatch($sformatf("abs_y %h, want %h", got.abs_y, e.abs_y));
            if (got.position_valid !== e.position_valid)
                report_mismatch($sformatf("position_valid %b, want %b",
                                          got.position_valid, e.position_valid));
            if (got.buttons !== e.buttons)
                report_mismatch($sformatf("buttons %b, want %b", got.buttons, e.buttons));
        endtask

        function int waiting();
            return expected_reports.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [15:0]        i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    lpa_pkg::t_in_item  i_in_item;
    logic               o_out_valid;
    logic               i_out_stall;
    lpa_pkg::t_out_item o_out_item;

    pen_average_scoreboard sb;
    bit in_fast;
    bit out_fast;
    int random_items;

    light_pen_position_averager_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #5000000;
        $display("tb_light_pen_position_averager_core NOT OK");
        $finish;
    end

    // results are checked before the same edge's request is noted
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_out_valid && !i_out_stall)
                sb.check_report(o_out_item);
            if (i_in_valid && !o_in_stall)
                sb.note_tick(i_in_item);
        end
    end

    initial begin : result_sink
        int hold;
        i_out_stall <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            hold = out_fast ? 0 : $urandom_range(0, 18);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    task automatic send_tick(input logic hit, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] pot);
        lpa_pkg::t_in_item req;
        int gap;
        req.pen_hit  = hit;
        req.pen_x    = x;
        req.pen_y    = y;
        req.pot_word = pot;
        gap = in_fast ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_item  <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // a forming tick keeps the divider busy after its own result is out
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        sb.write_register(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_averager(input logic [6:0] count, input logic [15:0] rmask,
                                    input logic [15:0] mmask);
        settle();
        write_reg(lpa_pkg::CFG_SAMPLE_COUNT, {9'd0, count});
        write_reg(lpa_pkg::CFG_RIGHT_MASK, rmask);
        write_reg(lpa_pkg::CFG_MIDDLE_MASK, mmask);
    endtask

    function automatic logic [15:0] rand_position();
        int v;
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            1: begin
                v = $urandom_range(0, 400) - 200;
                return v[15:0];
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_pot();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return ~sb.rmask;
            3: return ~sb.mmask;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_mask();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'h0001 << $urandom_range(0, 15);
        endcase
    endfunction

    task automatic run_ticks(input int n, input int hit_pct);
        in_fast  = ($urandom_range(0, 3) == 0);
        out_fast = ($urandom_range(0, 3) == 0);
        repeat (n) begin
            send_tick($urandom_range(0, 99) < hit_pct, rand_position(), rand_position(),
                      rand_pot());
            random_items++;
        end
    endtask

    initial begin : stimulus
        logic [6:0] count;
        int pct;
        sb = new();
        in_fast      = 1'b0;
        out_fast     = 1'b0;
        random_items = 0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= lpa_pkg::CFG_SAMPLE_COUNT;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: four-tick window, sums pushed past 16 bits
        send_tick(1'b1, 16'h7FFF, 16'h8000, 16'h0000);
        send_tick(1'b1, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_tick(1'b1, 16'h7FFF, 16'h8000, 16'h0400);
        send_tick(1'b1, 16'hFFFF, 16'h0001, 16'h0100);
        send_tick(1'b0, 16'h1234, 16'h5678, 16'h0500);
        // window without hits; the hit on the forming tick is ignored
        repeat (4) send_tick(1'b0, rand_position(), rand_position(), rand_pot());
        send_tick(1'b1, 16'h4000, 16'h4000, 16'hFBFF);
        // two hits: exactly at the threshold, negative mean truncates toward zero
        send_tick(1'b1, 16'hFFFB, 16'h0005, 16'hFEFF);
        send_tick(1'b0, 16'h7FFF, 16'h7FFF, 16'h0000);
        send_tick(1'b1, 16'h0000, 16'h0000, 16'hFFFF);
        send_tick(1'b0, 16'h8000, 16'h8000, 16'h0000);
        send_tick(1'b0, 16'h0000, 16'h0000, 16'h0400);
        // one hit: below threshold, shifted mean drops its high bits
        send_tick(1'b1, 16'h0100, 16'hFF80, 16'h0100);
        repeat (3) send_tick(1'b0, rand_position(), rand_position(), rand_pot());
        send_tick(1'b0, 16'h0000, 16'h0000, 16'h0000);
        repeat (2) send_tick(1'b0, rand_position(), rand_position(), rand_pot());

        // zero count: every tick forms; zero masks read as pressed
        program_averager(7'd0, 16'h0000, 16'h0000);
        run_ticks(10, 50);
        program_averager(7'd1, 16'hFFFF, 16'hFFFF);
        run_ticks(10, 50);
        program_averager(7'd127, 16'h0001 << $urandom_range(0, 15), 16'h8000);
        run_ticks(130, 90);

        // 128 hits in one window: count lowered below the tick index, hit count wraps
        program_averager(7'd0, pick_mask(), pick_mask());
        run_ticks(1, 50);
        program_averager(7'd100, sb.rmask, sb.mmask);
        run_ticks(5, 100);
        program_averager(7'd0, sb.rmask, sb.mmask);
        run_ticks(125, 100);

        while (random_items < 480) begin
            case ($urandom_range(0, 9))
                0: count = 7'd0;
                1: count = 7'd127;
                2: count = 7'($urandom_range(1, 127));
                default: count = 7'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 4))
                0: pct = 0;
                1: pct = 30;
                2: pct = 70;
                3: pct = 100;
                default: pct = $urandom_range(0, 100);
            endcase
            program_averager(count, pick_mask(), pick_mask());
            run_ticks($urandom_range(5, 40), pct);
        end

        settle();
        if (sb.errors == 0)
            $display("tb_light_pen_position_averager_core OK");
        else
            $display("tb_light_pen_position_averager_core NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
hw/rtl/lpa_pkg.sv
hw/rtl/lpa_div.sv
hw/rtl/lpa_dp.sv
hw/rtl/lpa_ctrl.sv
hw/rtl/light_pen_position_averager_core.sv
tb/tb_light_pen_position_averager_core.sv
